### hdl/bmpc_pkg.sv
// ============================================================================
// bmpc_pkg - shared types and constants of the back-emf motor pid controller
// tick and result payloads, register set, queued job and fixed codes
// ============================================================================
`default_nettype none

package bmpc_pkg;

    // operating modes
    localparam logic [1:0] MODE_PWM      = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;
    localparam logic [1:0] MODE_POSITION = 2'd2;
    localparam logic [1:0] MODE_RELATIVE = 2'd3;

    // drive directions
    localparam logic [1:0] DIR_BRAKE   = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    // register indexes
    localparam int         CFG_IDX_W    = 3;
    localparam logic [2:0] CFG_KP       = 3'd0;
    localparam logic [2:0] CFG_KI       = 3'd1;
    localparam logic [2:0] CFG_KD       = 3'd2;
    localparam logic [2:0] CFG_INT_LIM  = 3'd3;
    localparam logic [2:0] CFG_OUT_LIM  = 3'd4;
    localparam logic [2:0] CFG_DEADBAND = 3'd5;

    // register reset values
    localparam logic [13:0] INT_LIM_RESET  = 14'd10000;
    localparam logic [15:0] OUT_LIM_RESET  = 16'd400;
    localparam logic [7:0]  DEADBAND_RESET = 8'd8;

    // datapath widths
    localparam int ERR_W     = 18;
    localparam int DER_W     = 19;
    localparam int INTEG_W   = 15;
    localparam int P_KP_W    = 35;
    localparam int P_KI_W    = 32;
    localparam int P_KD_W    = 36;
    localparam int SUM_W     = 37;
    localparam int FRAC_BITS = 8;
    localparam int CMD_W     = SUM_W - FRAC_BITS;

    // job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] bemf_sample;
        logic signed [15:0] bemf_filtered;
        logic [1:0]         mode;
        logic signed [15:0] speed_goal;
        logic signed [31:0] position_goal;
        logic               stop_request;
        logic               clear_done;
    } tick_t;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [31:0] position;
        logic               drive_update;
        logic [1:0]         direction;
        logic [15:0]        duty;
        logic               done_res;
    } result_t;

    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [13:0] integral_limit;
        logic [15:0] output_limit;
        logic [7:0]  bemf_deadband;
    } cfg_t;

    // classified tick handed from the front to the back
    typedef struct packed {
        logic [1:0]              channel;
        logic                    present;
        logic                    stop;
        logic                    clr;
        logic                    pid_mode;
        logic                    pos_mode;
        logic                    goal_neg;
        logic signed [15:0]      filt;
        logic signed [31:0]      pgoal;
        logic signed [ERR_W-1:0] err;
    } job_t;

endpackage

`default_nettype wire

### hdl/bmpc_front.sv
// ============================================================================
// bmpc_front - tick intake and classification
// applies the deadband, forms the speed error and decodes mode and channel
// ============================================================================
`default_nettype none

module bmpc_front #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick_valid,
    output logic                  tick_stall,
    input  wire bmpc_pkg::tick_t  tick,
    input  wire bmpc_pkg::cfg_t   cfg,
    output logic                  job_valid,
    input  wire logic             job_stall,
    output bmpc_pkg::job_t        job
);
    import bmpc_pkg::*;

    logic               hold_reg;
    logic               hold_next;
    job_t               job_reg;
    job_t               job_next;
    logic               accept;
    logic signed [16:0] samp_ext;
    logic signed [16:0] db_pos;
    logic               in_band;
    logic signed [15:0] samp_db;

    assign tick_stall = hold_reg & job_stall;
    assign accept     = tick_valid & ~tick_stall;
    assign job_valid  = hold_reg;
    assign job        = job_reg;

    // deadband on the raw speed sample
    assign samp_ext = {tick.bemf_sample[15], tick.bemf_sample};
    assign db_pos   = $signed({9'b0, cfg.bemf_deadband});
    assign in_band  = (samp_ext < db_pos) && (samp_ext > -db_pos);
    assign samp_db  = in_band ? 16'sd0 : tick.bemf_sample;

    always_comb
    begin
        job_next          = job_reg;
        job_next.channel  = tick.channel;
        job_next.present  = ({30'b0, tick.channel} < 32'(NUM_CHANNELS));
        job_next.stop     = tick.stop_request;
        job_next.clr      = tick.clear_done;
        job_next.pid_mode = (tick.mode != MODE_PWM);
        job_next.pos_mode = (tick.mode == MODE_POSITION) || (tick.mode == MODE_RELATIVE);
        job_next.goal_neg = tick.speed_goal[15];
        job_next.filt     = tick.bemf_filtered;
        job_next.pgoal    = tick.position_goal;
        job_next.err      = {{2{tick.speed_goal[15]}}, tick.speed_goal}
                          - {{2{samp_db[15]}}, samp_db};
    end

    assign hold_next = accept | (hold_reg & job_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bmpc_queue.sv
// ============================================================================
// bmpc_queue - short job queue between front and back
// two entries, lets the intake and the pid sequencer stall on their own
// ============================================================================
`default_nettype none

module bmpc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_stall,
    input  wire bmpc_pkg::job_t  push_data,
    output logic                 pop_valid,
    input  wire logic            pop_take,
    output bmpc_pkg::job_t       pop_data
);
    import bmpc_pkg::*;

    job_t               entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid & ~push_stall;
    assign pop        = pop_valid & pop_take;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy never goes past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("job queue occupancy out of range");

endmodule

`default_nettype wire

### hdl/bmpc_back.sv
// ============================================================================
// bmpc_back - per-channel state and pid sequencer
// load, multiply, sum and finish steps, then the result register
// ============================================================================
`default_nettype none

module bmpc_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bmpc_pkg::cfg_t  cfg,
    input  wire logic            job_valid,
    output logic                 job_take,
    input  wire bmpc_pkg::job_t  job,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output bmpc_pkg::result_t    result
);
    import bmpc_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // per-channel state
    logic [31:0]               pos_reg   [NUM_CHANNELS];
    logic signed [ERR_W-1:0]   prev_reg  [NUM_CHANNELS];
    logic signed [INTEG_W-1:0] integ_reg [NUM_CHANNELS];
    logic                      done_reg  [NUM_CHANNELS];

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // work registers of the item in flight
    logic [1:0]                w_channel_reg;
    logic [IDX_W-1:0]          w_idx_reg;
    logic                      w_present_reg;
    logic                      w_stop_reg;
    logic                      w_run_reg;
    logic                      w_pos_mode_reg;
    logic                      w_passed_reg;
    logic                      w_done_reg;
    logic [31:0]               w_pos_reg;
    logic signed [ERR_W-1:0]   w_err_reg;
    logic signed [DER_W-1:0]   w_der_reg;
    logic signed [INTEG_W-1:0] w_integ_reg;

    logic signed [P_KP_W-1:0] p_kp_reg;
    logic signed [P_KI_W-1:0] p_ki_reg;
    logic signed [P_KD_W-1:0] p_kd_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    // load step signals
    logic                      pop;
    logic [IDX_W-1:0]          idx;
    logic                      done_cur;
    logic [31:0]               pos_new;
    logic signed [DER_W-1:0]   err_ext;
    logic signed [DER_W-1:0]   der;
    logic signed [DER_W-1:0]   integ_sum;
    logic signed [DER_W-1:0]   ilim;
    logic signed [INTEG_W-1:0] integ_new;
    logic                      passed;

    // finish step signals
    logic                    out_free;
    logic                    finish;
    logic signed [SUM_W-1:0] biased;
    logic signed [CMD_W-1:0] cmd_q;
    logic signed [CMD_W-1:0] cmd_sel;
    logic signed [CMD_W-1:0] olim;
    logic signed [CMD_W-1:0] cmd_sat;
    logic signed [CMD_W-1:0] cmd_mag;
    logic                    done_new;

    assign pop      = (state_reg == ST_LOAD) && job_valid;
    assign job_take = pop;

    // load: read channel state, update position, error terms and goal check
    assign idx       = IDX_W'({30'b0, job.channel});
    assign done_cur  = job.clr ? 1'b0 : done_reg[idx];
    assign pos_new   = pos_reg[idx] + {{16{job.filt[15]}}, job.filt};
    assign err_ext   = {job.err[ERR_W-1], job.err};
    assign der       = err_ext - {prev_reg[idx][ERR_W-1], prev_reg[idx]};
    assign integ_sum = DER_W'(integ_reg[idx]) + err_ext;
    assign ilim      = $signed({5'b0, cfg.integral_limit});

    always_comb
    begin
        if (integ_sum > ilim)
        begin
            integ_new = INTEG_W'(ilim);
        end
        else if (integ_sum < -ilim)
        begin
            integ_new = INTEG_W'(-ilim);
        end
        else
        begin
            integ_new = INTEG_W'(integ_sum);
        end
    end

    assign passed = job.goal_neg ? ($signed(pos_new) < job.pgoal)
                                 : ($signed(pos_new) > job.pgoal);

    // finish: truncate toward zero, goal override, saturate, split
    assign out_free = ~out_valid_reg | ~result_stall;
    assign finish   = (state_reg == ST_OUT) && out_free;
    assign biased   = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
    assign cmd_q    = biased[SUM_W-1:FRAC_BITS];
    assign cmd_sel  = (w_pos_mode_reg && w_passed_reg) ? CMD_W'(0) : cmd_q;
    assign olim     = $signed({13'b0, cfg.output_limit});

    always_comb
    begin
        if (cmd_sel > olim)
        begin
            cmd_sat = olim;
        end
        else if (cmd_sel < -olim)
        begin
            cmd_sat = -olim;
        end
        else
        begin
            cmd_sat = cmd_sel;
        end
    end

    assign cmd_mag  = cmd_sat[CMD_W-1] ? -cmd_sat : cmd_sat;
    assign done_new = w_done_reg | (w_run_reg & w_pos_mode_reg & w_passed_reg);

    always_comb
    begin
        out_next              = out_reg;
        out_next.out_channel  = w_channel_reg;
        out_next.position     = w_present_reg ? $signed(w_pos_reg) : 32'sd0;
        out_next.drive_update = w_present_reg & (w_stop_reg | w_run_reg);
        out_next.direction    = DIR_BRAKE;
        out_next.duty         = '0;
        out_next.done_res     = w_present_reg & done_new;
        if (w_present_reg && !w_stop_reg && w_run_reg)
        begin
            out_next.direction = cmd_sat[CMD_W-1] ? DIR_REVERSE : DIR_FORWARD;
            out_next.duty      = cmd_mag[15:0];
        end
    end

    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (job_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // channel state, written back when the item finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pos_reg[i]   <= '0;
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
                done_reg[i]  <= 1'b0;
            end
        end
        else if (finish && w_present_reg)
        begin
            pos_reg[w_idx_reg]  <= w_pos_reg;
            done_reg[w_idx_reg] <= done_new;
            if (w_run_reg)
            begin
                prev_reg[w_idx_reg]  <= w_err_reg;
                integ_reg[w_idx_reg] <= w_integ_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_channel_reg  <= job.channel;
            w_idx_reg      <= idx;
            w_present_reg  <= job.present;
            w_stop_reg     <= job.stop;
            w_run_reg      <= ~job.stop & job.pid_mode & ~done_cur;
            w_pos_mode_reg <= job.pos_mode;
            w_passed_reg   <= passed;
            w_done_reg     <= done_cur;
            w_pos_reg      <= pos_new;
            w_err_reg      <= job.err;
            w_der_reg      <= der;
            w_integ_reg    <= integ_new;
        end
        if (state_reg == ST_MUL)
        begin
            p_kp_reg <= $signed({1'b0, cfg.kp_gain}) * w_err_reg;
            p_ki_reg <= $signed({1'b0, cfg.ki_gain}) * w_integ_reg;
            p_kd_reg <= $signed({1'b0, cfg.kd_gain}) * w_der_reg;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= SUM_W'(p_kp_reg) + SUM_W'(p_ki_reg) + SUM_W'(p_kd_reg);
        end
        if (finish)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a taken job passes through the multiply and sum steps to the finish step
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ##3 (state_reg == ST_OUT))
        else $error("pid sequence length broken");

    // a result without a drive change carries brake and zero duty
    a_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.drive_update)
            |-> (out_reg.duty == '0 && out_reg.direction == DIR_BRAKE))
        else $error("idle drive fields not cleared");

    // a stop on a present channel brakes with zero duty
    a_stop_brake: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && w_present_reg && w_stop_reg)
            |=> (out_reg.drive_update && out_reg.direction == DIR_BRAKE
                 && out_reg.duty == '0))
        else $error("stop transfer did not brake");

endmodule

`default_nettype wire

### hdl/bemf_motor_pid_controller.sv
// ============================================================================
// bemf_motor_pid_controller - back-emf speed and position pid controller
// per-channel position tracking, clamped-integral pid and goal detection
// ============================================================================
//
// channel   signals                              direction  transfer when
// -------   -----------------------------------  ---------  ---------------------
// tick      tick_valid, tick_stall, tick         in         valid high, stall low
// result    result_valid, result_stall, result   out        valid high, stall low
// config    cfg_valid, cfg_ready, cfg_index,     in         valid and ready high
//           cfg_data
//
// each tick passes through the pid sequencer steps load, multiply, sum and finish;
// the result register is loaded in the finish step
// the sequencer handles one tick at a time, which keeps channel state coherent
// the front stage and a two-entry queue keep taking ticks while it works, until they are full
// reset clears all channel state and sets the register set to its reset values at once, no clearing pass
// a stalled result holds the sequencer in its finish step
// ============================================================================
`default_nettype none

module bemf_motor_pid_controller #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               tick_valid,
    output logic                                    tick_stall,
    input  wire bmpc_pkg::tick_t                    tick,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output bmpc_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bmpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                        cfg_data
);
    import bmpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_write;

    // front to queue
    logic fq_valid;
    logic fq_stall;
    job_t fq_job;

    // queue to back
    logic qb_valid;
    logic qb_take;
    job_t qb_job;

    // register file, always ready; writes must land only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_index)
            CFG_KP:       cfg_next.kp_gain        = cfg_data;
            CFG_KI:       cfg_next.ki_gain        = cfg_data;
            CFG_KD:       cfg_next.kd_gain        = cfg_data;
            CFG_INT_LIM:  cfg_next.integral_limit = cfg_data[13:0];
            CFG_OUT_LIM:  cfg_next.output_limit   = cfg_data;
            CFG_DEADBAND: cfg_next.bemf_deadband  = cfg_data[7:0];
            default:      cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain        <= '0;
            cfg_reg.ki_gain        <= '0;
            cfg_reg.kd_gain        <= '0;
            cfg_reg.integral_limit <= INT_LIM_RESET;
            cfg_reg.output_limit   <= OUT_LIM_RESET;
            cfg_reg.bemf_deadband  <= DEADBAND_RESET;
        end
        else if (cfg_write)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // intake: deadband, speed error, mode decode
    bmpc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .cfg        (cfg_reg),
        .job_valid  (fq_valid),
        .job_stall  (fq_stall),
        .job        (fq_job)
    );

    // decoupling queue
    bmpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_take   (qb_take),
        .pop_data   (qb_job)
    );

    // channel state, pid arithmetic and result register
    bmpc_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (qb_valid),
        .job_take     (qb_take),
        .job          (qb_job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### tb/tb_bemf_motor_pid_controller.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bemf_motor_pid_controller - self-checking regression of the motor pid
// ticks go in over a valid/stall channel, drive results come back the same
// way; an in-order predictor of positions, pid state and done flags gives
// the expected result of every accepted tick, compared field by field
// ============================================================================

module tb_bemf_motor_pid_controller;

    import bmpc_pkg::*;

    localparam int      CHANNELS      = 4;
    localparam int      SETTLE_CYCLES = 10;       // extra quiet time once every owed result is back
    localparam int      LONG_HOLD     = 200;      // receiver hold-off, in cycles
    localparam int      PHASE_TICKS   = 130;      // random ticks per register setting
    localparam int      WRAP_TICKS    = 64;       // bound on ticks to carry a channel past 0
    localparam longint  CYCLE_LIMIT   = 200000;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic                 tick_valid;
    logic                 tick_stall;
    tick_t                tick;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    bemf_motor_pid_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: register copy plus per-channel controller state
    // ------------------------------------------------------------------------
    cfg_t               model_cfg;
    logic [31:0]        pos_acc   [CHANNELS];
    logic signed [17:0] last_err  [CHANNELS];
    logic signed [14:0] integ_acc [CHANNELS];
    logic               done_flag [CHANNELS];

    result_t pending_drives[$];     // drive results still owed by the block

    int     errors        = 0;
    int     ticks_sent    = 0;
    longint cycle_count   = 0;
    bit     idle_on       = 1'b1;   // random gaps on both sides
    bit     long_hold_req = 1'b0;   // asks the receiver for one long hold-off

    // signed value spread evenly over -span..span
    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // expected drive result of one tick; advances the channel state
    function automatic result_t drive_for_tick(input tick_t t);
        result_t     r;
        int unsigned ch;
        longint      speed;
        longint      err;
        longint      slope;
        longint      integ;
        longint      total;
        longint      cmd;
        longint      lim_i;
        longint      lim_o;
        longint      band;
        logic [31:0] pos;
        bit          passed;

        ch            = t.channel;
        r             = '0;
        r.out_channel = t.channel;
        passed        = 1'b0;

        if (t.clear_done)
            done_flag[ch] = 1'b0;

        // samples strictly inside the deadband read as standstill
        speed = longint'($signed(t.bemf_sample));
        band  = longint'(model_cfg.bemf_deadband);
        if (speed < band && speed > -band)
            speed = 0;

        // position keeps running in every case, 32-bit wrap
        pos         = pos_acc[ch] + {{16{t.bemf_filtered[15]}}, t.bemf_filtered};
        pos_acc[ch] = pos;

        if (t.stop_request)
        begin
            r.drive_update = 1'b1;
            r.direction    = DIR_BRAKE;
            r.duty         = '0;
        end
        else if (t.mode != MODE_PWM && !done_flag[ch])
        begin
            lim_i = longint'(model_cfg.integral_limit);
            lim_o = longint'(model_cfg.output_limit);
            err   = longint'($signed(t.speed_goal)) - speed;
            slope = err - longint'(last_err[ch]);
            integ = longint'(integ_acc[ch]) + err;
            if (integ > lim_i)
                integ = lim_i;
            else if (integ < -lim_i)
                integ = -lim_i;
            last_err[ch]  = err[17:0];
            integ_acc[ch] = integ[14:0];

            // q8.8 gains, exact sum, truncated toward zero
            total = longint'(model_cfg.kp_gain) * err
                  + longint'(model_cfg.ki_gain) * integ
                  + longint'(model_cfg.kd_gain) * slope;
            cmd   = total / 256;

            // goal passed in the direction of motion, zero goal counts forward
            if (t.mode == MODE_POSITION || t.mode == MODE_RELATIVE)
            begin
                if ($signed(t.speed_goal) < 0)
                    passed = $signed(pos) < $signed(t.position_goal);
                else
                    passed = $signed(pos) > $signed(t.position_goal);
                if (passed)
                begin
                    cmd           = 0;
                    done_flag[ch] = 1'b1;
                end
            end

            if (cmd > lim_o)
                cmd = lim_o;
            if (cmd < -lim_o)
                cmd = -lim_o;

            r.drive_update = 1'b1;
            if (cmd < 0)
            begin
                r.direction = DIR_REVERSE;
                r.duty      = 16'(-cmd);
            end
            else
            begin
                r.direction = DIR_FORWARD;
                r.duty      = 16'(cmd);
            end
        end

        r.position = pos;
        r.done_res = done_flag[ch];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // tick sender: valid stays up between back-to-back transfers
    // ------------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        tick       <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        pending_drives.push_back(drive_for_tick(t));
        ticks_sent++;
    endtask

    function automatic tick_t tick_of(input int ch, input int sample, input int filt,
                                      input logic [1:0] mode, input int sgoal,
                                      input logic [31:0] pgoal, input bit stop,
                                      input bit clr);
        tick_t t;
        t.channel       = 2'(ch);
        t.bemf_sample   = 16'(sample);
        t.bemf_filtered = 16'(filt);
        t.mode          = mode;
        t.speed_goal    = 16'(sgoal);
        t.position_goal = pgoal;
        t.stop_request  = stop;
        t.clear_done    = clr;
        return t;
    endfunction

    // drop valid and wait until every owed result is back and the block is quiet
    task automatic settle();
        tick_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // register writes, only ever issued while the block is idle
    // ------------------------------------------------------------------------
    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_KP:       model_cfg.kp_gain        = data;
            CFG_KI:       model_cfg.ki_gain        = data;
            CFG_KD:       model_cfg.kd_gain        = data;
            CFG_INT_LIM:  model_cfg.integral_limit = data[13:0];
            CFG_OUT_LIM:  model_cfg.output_limit   = data;
            CFG_DEADBAND: model_cfg.bemf_deadband  = data[7:0];
            default:      ;
        endcase
    endtask

    // unused upper data bits of the narrow registers carry random junk
    task automatic write_settings(input cfg_t c, input logic [15:0] junk);
        settle();
        cfg_transfer(CFG_KP, c.kp_gain);
        cfg_transfer(CFG_KI, c.ki_gain);
        cfg_transfer(CFG_KD, c.kd_gain);
        cfg_transfer(CFG_INT_LIM, {junk[15:14], c.integral_limit});
        cfg_transfer(CFG_OUT_LIM, c.output_limit);
        cfg_transfer(CFG_DEADBAND, {junk[15:8], c.bemf_deadband});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------------

    // a well-formed move: clear done, then a few ticks heading for a nearby goal
    task automatic run_move();
        tick_t t;
        int    dir_sign;
        int    steps;
        int    k;

        dir_sign  = $urandom_range(0, 1) ? 1 : -1;
        steps     = $urandom_range(3, 10);
        t.channel = 2'($urandom);
        case ($urandom_range(0, 3))
            0:       t.mode = MODE_VELOCITY;
            1:       t.mode = MODE_POSITION;
            default: t.mode = MODE_RELATIVE;
        endcase
        t.speed_goal    = 16'(dir_sign * int'($urandom_range(0, 1500)));
        t.position_goal = pos_acc[t.channel]
                        + 32'(dir_sign * int'($urandom_range(0, 8000)));
        for (k = 0; k < steps; k++)
        begin
            t.bemf_sample   = 16'($signed(t.speed_goal) + rand_span(400));
            t.bemf_filtered = 16'(dir_sign * int'($urandom_range(0, 2500)));
            t.stop_request  = ($urandom_range(0, 19) == 0);
            t.clear_done    = (k == 0);
            send_tick(t);
        end
    endtask

    // noise tick, full-range fields
    task automatic send_noise_tick();
        tick_t t;
        t.channel       = 2'($urandom);
        t.bemf_sample   = 16'($urandom);
        t.bemf_filtered = 16'($urandom);
        t.mode          = 2'($urandom);
        t.speed_goal    = 16'($urandom);
        if ($urandom_range(0, 1))
            t.position_goal = 32'($urandom);
        else
            t.position_goal = pos_acc[t.channel] + 32'(rand_span(30000));
        t.stop_request  = ($urandom_range(0, 7) == 0);
        t.clear_done    = ($urandom_range(0, 3) == 0);
        send_tick(t);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values: zero gains, deadband 8, integral clamp, output clamp
    task automatic test_reset_values();
        send_tick(tick_of(0, 7, 3, MODE_VELOCITY, 0, 0, 0, 0));
        send_tick(tick_of(0, -7, -3, MODE_VELOCITY, 0, 0, 0, 0));
        send_tick(tick_of(0, 8, 0, MODE_VELOCITY, 0, 0, 0, 0));
        send_tick(tick_of(0, -8, 0, MODE_VELOCITY, 0, 0, 0, 0));
        // big error twice so the integral runs into its reset clamp
        send_tick(tick_of(3, -32768, 0, MODE_VELOCITY, 32767, 0, 0, 0));
        send_tick(tick_of(3, -32768, 0, MODE_VELOCITY, 32767, 0, 0, 0));
        settle();
        // unity kp alone, output still clamped by its reset limit
        cfg_transfer(CFG_KP, 16'd256);
        cfg_valid <= 1'b0;
        send_tick(tick_of(0, 0, 0, MODE_VELOCITY, 1000, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, MODE_VELOCITY, -1000, 0, 0, 0));
    endtask

    // goal passing, done flag, stop, clear, pwm and every mode
    task automatic test_goal_and_done();
        cfg_t c;
        c = '{kp_gain: 16'd256, ki_gain: 16'd0, kd_gain: 16'd0, integral_limit: 14'd10000,
              output_limit: 16'd400, bemf_deadband: 8'd8};
        write_settings(c, 16'h0000);
        send_tick(tick_of(1, 0, 100, MODE_POSITION, 100, 50, 0, 1));     // passes, done
        send_tick(tick_of(1, 0, 0, MODE_VELOCITY, 100, 0, 0, 0));       // done holds drive
        send_tick(tick_of(1, 0, 0, MODE_VELOCITY, 100, 0, 1, 0));       // stop while done
        send_tick(tick_of(1, 0, 0, MODE_VELOCITY, 100, 0, 0, 1));       // cleared, runs again
        send_tick(tick_of(2, 0, -100, MODE_RELATIVE, -100, -50, 0, 1)); // reverse goal passed
        send_tick(tick_of(0, 0, 0, MODE_POSITION, 0, 10, 0, 1));        // zero goal, not yet
        send_tick(tick_of(0, 0, 20, MODE_POSITION, 0, 10, 0, 0));       // zero goal is forward
        send_tick(tick_of(0, 200, 0, MODE_VELOCITY, -300, 0, 0, 1));    // saturates reverse
        send_tick(tick_of(0, 200, 0, MODE_PWM, -300, 0, 0, 0));         // pwm leaves drive
    endtask

    // extremes of every field with maximum gains and limits
    task automatic test_field_extremes();
        cfg_t c;
        c = '{kp_gain: 16'hFFFF, ki_gain: 16'hFFFF, kd_gain: 16'hFFFF,
              integral_limit: 14'h3FFF, output_limit: 16'hFFFF, bemf_deadband: 8'hFF};
        write_settings(c, 16'hFFFF);
        send_tick(tick_of(2, -32768, 32767, MODE_VELOCITY, 32767, 0, 0, 1));
        send_tick(tick_of(2, 32767, -32768, MODE_VELOCITY, -32768, 0, 0, 0));
        send_tick(tick_of(2, 254, 32767, MODE_POSITION, 32767, 32'h7FFF_FFFF, 0, 0));
        send_tick(tick_of(2, -254, -32768, MODE_RELATIVE, -32768, 32'h8000_0000, 0, 1));
        send_tick(tick_of(2, 255, 0, MODE_VELOCITY, 0, 32'hFFFF_FFFF, 0, 0));
        send_tick(tick_of(3, -32768, -32768, MODE_RELATIVE, -1, 32'h8000_0000, 1, 1));
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        int k;
        settle();
        idle_on       = 1'b0;
        long_hold_req = 1'b1;
        for (k = 0; k < 24; k++)
            send_noise_tick();
        settle();
        idle_on = 1'b1;
    endtask

    // carry one channel's position through zero, across the 32-bit wrap
    task automatic test_position_wrap();
        int k;
        bit start_neg;
        settle();
        idle_on   = 1'b0;
        start_neg = pos_acc[3][31];
        for (k = 0; k < WRAP_TICKS && pos_acc[3][31] == start_neg; k++)
            send_tick(tick_of(3, 0, start_neg ? 32767 : -32768, MODE_PWM, 0, 0, 0, 0));
        // goal checks close to the wrapped position
        send_tick(tick_of(3, 0, 0, MODE_POSITION, 500, pos_acc[3] - 32'd1, 0, 1));
        send_tick(tick_of(3, 0, 100, MODE_POSITION, -500, pos_acc[3] + 32'd50, 0, 1));
        settle();
        idle_on = 1'b1;
    endtask

    // random moves and noise under a sequence of register settings
    task automatic test_random_phases();
        cfg_t c;
        int   phase;
        int   start;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: c = '{kp_gain: 16'd256, ki_gain: 16'd32, kd_gain: 16'd64,
                         integral_limit: 14'd2000, output_limit: 16'd400,
                         bemf_deadband: 8'd8};
                1: c = '{kp_gain: 16'hFFFF, ki_gain: 16'hFFFF, kd_gain: 16'hFFFF,
                         integral_limit: 14'h3FFF, output_limit: 16'hFFFF,
                         bemf_deadband: 8'hFF};
                2: c = '0;
                default:
                begin
                    c.kp_gain        = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023))
                                                            : 16'($urandom);
                    c.ki_gain        = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                                            : 16'($urandom);
                    c.kd_gain        = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023))
                                                            : 16'($urandom);
                    c.integral_limit = 14'($urandom);
                    c.output_limit   = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                                            : 16'($urandom);
                    c.bemf_deadband  = 8'($urandom);
                end
            endcase
            write_settings(c, 16'($urandom));
            // the closing phase runs with no gaps on either side
            idle_on = (phase != 5);
            start   = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS)
            begin
                if (phase != 5 && $urandom_range(0, 7) == 0)
                    idle_on = !idle_on;
                if ($urandom_range(0, 9) < 7)
                    run_move();
                else
                    send_noise_tick();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver stall: random bursts, or one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : result_backpressure
        int held;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every transfer against the oldest owed result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint want, input longint got);
        errors++;
        if (errors <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result on channel %0d", result.out_channel);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (result.out_channel !== want.out_channel)
                    report_mismatch("out_channel", want.out_channel, result.out_channel);
                if (result.position !== want.position)
                    report_mismatch("position", $signed(want.position),
                                    $signed(result.position));
                if (result.drive_update !== want.drive_update)
                    report_mismatch("drive_update", want.drive_update, result.drive_update);
                if (result.direction !== want.direction)
                    report_mismatch("direction", want.direction, result.direction);
                if (result.duty !== want.duty)
                    report_mismatch("duty", want.duty, result.duty);
                if (result.done_res !== want.done_res)
                    report_mismatch("done_res", want.done_res, result.done_res);
            end
        end
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bemf_motor_pid_controller regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin : regression
        int i;

        // predictor starts from the reset state of the block
        model_cfg = '{kp_gain: 16'd0, ki_gain: 16'd0, kd_gain: 16'd0,
                      integral_limit: INT_LIM_RESET, output_limit: OUT_LIM_RESET,
                      bemf_deadband: DEADBAND_RESET};
        for (i = 0; i < CHANNELS; i++)
        begin
            pos_acc[i]   = '0;
            last_err[i]  = '0;
            integ_acc[i] = '0;
            done_flag[i] = 1'b0;
        end

        rst_n      <= 1'b0;
        tick_valid <= 1'b0;
        tick       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_KP;
        cfg_data   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_goal_and_done();
        test_field_extremes();
        test_backpressure();
        test_position_wrap();
        test_random_phases();

        settle();
        if (errors == 0)
            $display("bemf_motor_pid_controller regression: pass");
        else
            $display("bemf_motor_pid_controller regression: fail");
        $finish;
    end

endmodule
